FILE: sv/mpq_pkg.sv
// Package for the max priority queue: payload types, cell types and codes.
// No dependencies; compiled first.
package mpq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 32;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    // Contents of one cell of the sorted row
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] data;
    } cell_state_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic                      push;
        logic                      pop;
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

FILE: sv/mpq_if.sv
// Request and response channel interfaces of the max priority queue.
// Depends on mpq_pkg.
interface mpq_req_if;
    import mpq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface mpq_rsp_if;
    import mpq_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [VALUE_W-1:0]     max_value;
    logic [COUNT_OUT_W-1:0]        count;
    logic                          is_empty;
    logic [1:0]                    error;

    modport source (output valid, output max_value, output count, output is_empty,
                    output error, input ready);
    modport sink   (input valid, input max_value, input count, input is_empty,
                    input error, output ready);
endinterface

FILE: sv/mpq_cell.sv
// One cell of the sorted row: holds one entry, inserts or shifts with neighbors.
// Depends on mpq_pkg.
module mpq_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mpq_pkg::cell_cmd_t   cmd,
    input  mpq_pkg::cell_state_t up_state,
    input  logic                 up_ge,
    input  mpq_pkg::cell_state_t dn_state,
    output mpq_pkg::cell_state_t cur,
    output mpq_pkg::cell_state_t nxt,
    output logic                 ge
);
    import mpq_pkg::*;

    logic                      valid_reg;
    logic signed [VALUE_W-1:0] data_reg;

    assign cur.valid = valid_reg;
    assign cur.data  = data_reg;

    // Keep entry when it is at least the pushed value (ties stay above)
    assign ge = valid_reg && ($signed(data_reg) >= $signed(cmd.value));

    // Insert, shift down on push; shift up on pop
    always_comb
    begin
        nxt = cur;
        if (cmd.push && !ge)
        begin
            if (up_ge)
            begin
                nxt.valid = 1'b1;
                nxt.data  = cmd.value;
            end
            else
            begin
                nxt = up_state;
            end
        end
        else if (cmd.pop)
        begin
            nxt = dn_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= nxt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= nxt.data;
    end

endmodule

FILE: sv/max_priority_queue_top.sv
// Top level of the max priority queue: a row of sorted cells plus count and
// response register. Depends on mpq_pkg, mpq_if and mpq_cell.
//
//  channel | dir | fields                               | handshake
//  req     | in  | func, value                          | valid/ready
//  rsp     | out | max_value, count, is_empty, error    | valid/ready
//
// For each operation the whole cell row compares against the pushed value
// in parallel and inserts or shifts in a single step.
// The result is held in an output register; a new transaction is taken
// whenever that register is empty or being read, so up to one per cycle.
// Reset clears the cell valid bits and the count; no clearing pass is needed.
// A stalled response blocks new requests only while the register is full.
module max_priority_queue_top #(
    parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    mpq_req_if.sink   req,
    mpq_rsp_if.source rsp
);
    import mpq_pkg::*;

    localparam int COUNT_W = $clog2(DEPTH + 1);

    cell_state_t cell_q [DEPTH];
    cell_state_t cell_d [DEPTH];
    logic        ge     [DEPTH];
    cell_cmd_t   cmd;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               in_fire;
    logic               is_push;
    logic               full;
    logic               empty;
    err_t               err;
    logic [COUNT_W+COUNT_OUT_W-1:0] count_ext;

    logic                      rsp_valid_reg;
    logic signed [VALUE_W-1:0] max_reg;
    logic [COUNT_OUT_W-1:0]    count_out_reg;
    logic                      empty_reg;
    err_t                      err_reg;

    // Accept when the response register is free or drains this cycle
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign in_fire   = req.valid && req.ready;
    assign is_push   = (req.func == FUNC_PUSH);
    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    assign cmd.push  = in_fire && is_push && !full;
    assign cmd.pop   = in_fire && !is_push && !empty;
    assign cmd.value = req.value;

    // Error code and next count
    always_comb
    begin
        err        = ERR_OK;
        count_next = count_reg;
        if (in_fire)
        begin
            if (is_push)
            begin
                if (full)
                    err = ERR_FULL;
                else
                    count_next = count_reg + COUNT_W'(1);
            end
            else
            begin
                if (empty)
                    err = ERR_EMPTY;
                else
                    count_next = count_reg - COUNT_W'(1);
            end
        end
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    // Row of cells, kept sorted descending from cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_state_t up_s;
        cell_state_t dn_s;
        logic        up_g;

        if (i == 0)
        begin : g_first
            assign up_s = '0;
            assign up_g = 1'b1;
        end
        else
        begin : g_mid
            assign up_s = cell_q[i-1];
            assign up_g = ge[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign dn_s = '0;
        end
        else
        begin : g_below
            assign dn_s = cell_q[i+1];
        end

        mpq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .up_state (up_s),
            .up_ge    (up_g),
            .dn_state (dn_s),
            .cur      (cell_q[i]),
            .nxt      (cell_d[i]),
            .ge       (ge[i])
        );
    end

    // Hold count and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Capture the result of each transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            max_reg       <= cell_d[0].valid ? cell_d[0].data : '0;
            count_out_reg <= count_ext[COUNT_OUT_W-1:0];
            empty_reg     <= (count_next == '0);
            err_reg       <= err;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.max_value = max_reg;
    assign rsp.count     = count_out_reg;
    assign rsp.is_empty  = empty_reg;
    assign rsp.error     = err_reg;

    // Head cell is occupied exactly when the count is nonzero
    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        cell_q[0].valid == (count_reg != '0))
        else $error("head cell occupancy disagrees with count");

    // Row stays sorted at the top
    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        cell_q[1].valid |-> ($signed(cell_q[0].data) >= $signed(cell_q[1].data)))
        else $error("cell row out of order");

    // A successful pop lowers the count by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (count_reg == $past(count_reg) - COUNT_W'(1)))
        else $error("pop did not decrement count");

    // A full flag only on a push at full capacity
    a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && err == ERR_FULL) |-> (is_push && count_reg == COUNT_W'(DEPTH)))
        else $error("full error raised while not full");

endmodule
